### rtl/ics_pkg.sv
`timescale 1ns / 1ps
// ics_pkg: field widths, action and mode codes for the internet checksum block
// no dependencies; used by the channel interfaces and the top level

package ics_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PROTO_W  = 8;
  localparam int unsigned SUM_W    = 16;

  // action codes carried with every input word
  localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADDR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_END  = 2'd2;

  // checksum modes, sampled on the end word
  localparam logic [MODE_W-1:0] MODE_L3      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IPV4    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IPV6    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

endpackage

### rtl/ics_in_if.sv
`timescale 1ns / 1ps
// ics_in_if: input channel of the checksum block (valid/ready plus fields)
// depends on ics_pkg for field widths

interface ics_in_if import ics_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   data_value;
  logic [MODE_W-1:0]   mode;
  logic [PROTO_W-1:0]  l4_protocol;

  modport source (output valid, action, data_value, mode, l4_protocol, input ready);
  modport sink (input valid, action, data_value, mode, l4_protocol, output ready);
endinterface

### rtl/ics_out_if.sv
`timescale 1ns / 1ps
// ics_out_if: result channel of the checksum block (valid/ready plus checksum)
// depends on ics_pkg for the checksum width

interface ics_out_if import ics_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] checksum;

  modport source (output valid, checksum, input ready);
  modport sink (input valid, checksum, output ready);
endinterface

### rtl/internet_checksum_pseudo_header.sv
`timescale 1ns / 1ps
// internet_checksum_pseudo_header: one's-complement checksum with tcp/udp pseudo-header
// depends on ics_pkg, ics_in_if and ics_out_if
//
// an end word waits in the input register; its checksum is then held in the result register
// throughput: one word per cycle; the input register stalls only when an end
//   word finds the result register full and not being taken this cycle
// reset (rst, synchronous, active high) empties both registers and clears all sums

module internet_checksum_pseudo_header import ics_pkg::*; (
  input  logic clk,
  input  logic rst,
  ics_in_if.sink    req,
  ics_out_if.source rsp
);

  // 16-bit add with end-around carry
  function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
  endfunction

  // input register
  logic                s1_valid;
  logic [ACTION_W-1:0] s1_action;
  logic [DATA_W-1:0]   s1_value;
  logic [MODE_W-1:0]   s1_mode;
  logic [PROTO_W-1:0]  s1_proto;

  // running state
  logic [SUM_W-1:0] data_sum;
  logic [SUM_W-1:0] pseudo_sum;
  logic [7:0]       held_high_byte;
  logic             odd_byte_pending;
  logic [15:0]      byte_count;

  // result register
  logic             out_valid;
  logic [SUM_W-1:0] out_sum;

  logic out_free;
  logic s1_is_end;
  logic s1_adv;

  assign out_free  = !out_valid || rsp.ready;
  assign s1_is_end = (s1_action == ACT_END);
  // a word that makes no result never waits on the output side
  assign s1_adv    = s1_valid && (!s1_is_end || out_free);
  assign req.ready = !s1_valid || s1_adv;

  assign rsp.valid    = out_valid;
  assign rsp.checksum = out_sum;

  // end-of-packet total: five terms summed wide, then folded twice;
  // the folded sum matches a chain of end-around adds, zero included
  logic [SUM_W-1:0] odd_word;
  logic [SUM_W-1:0] pseudo_term;
  logic [SUM_W-1:0] proto_term;
  logic [SUM_W-1:0] count_term;
  logic [SUM_W+2:0] wide_sum;
  logic [SUM_W:0]   fold1;
  logic [SUM_W-1:0] fold2;
  logic [SUM_W-1:0] end_result;

  always_comb begin
    odd_word    = odd_byte_pending ? {held_high_byte, 8'h00} : '0;
    pseudo_term = '0;
    proto_term  = '0;
    count_term  = '0;
    unique case (s1_mode)
      MODE_IPV4: begin
        pseudo_term = pseudo_sum;
        proto_term  = {{(SUM_W-PROTO_W){1'b0}}, s1_proto};
        count_term  = byte_count;
      end
      MODE_IPV6: begin
        pseudo_term = pseudo_sum;
        // ipv6 folds the protocol into the length with a plain 16-bit wrap
        count_term  = byte_count + {{(SUM_W-PROTO_W){1'b0}}, s1_proto};
      end
      MODE_L3, MODE_UNKNOWN: begin
        pseudo_term = '0;
      end
    endcase
    wide_sum = {3'b000, data_sum} + {3'b000, odd_word} + {3'b000, pseudo_term}
             + {3'b000, proto_term} + {3'b000, count_term};
    fold1    = {1'b0, wide_sum[SUM_W-1:0]} + {{(SUM_W-2){1'b0}}, wide_sum[SUM_W+2:SUM_W]};
    fold2    = fold1[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, fold1[SUM_W]};
    end_result = (s1_mode == MODE_UNKNOWN) ? '0 : ~fold2;
  end

  // input register: payload held until the word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      s1_action <= req.action;
      s1_value  <= req.data_value;
      s1_mode   <= req.mode;
      s1_proto  <= req.l4_protocol;
    end
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_sum         <= '0;
      pseudo_sum       <= '0;
      held_high_byte   <= '0;
      odd_byte_pending <= 1'b0;
      byte_count       <= '0;
      out_valid        <= 1'b0;
    end else begin
      // a new checksum wins over the one being taken this cycle
      if (s1_adv && s1_is_end) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv) begin
        unique case (s1_action)
          ACT_BYTE: begin
            if (odd_byte_pending) begin
              data_sum         <= oc_add(data_sum, {held_high_byte, s1_value[7:0]});
              odd_byte_pending <= 1'b0;
              held_high_byte   <= '0;
            end else begin
              held_high_byte   <= s1_value[7:0];
              odd_byte_pending <= 1'b1;
            end
            byte_count <= byte_count + 16'd1;
          end
          ACT_ADDR: begin
            pseudo_sum <= oc_add(pseudo_sum, s1_value);
          end
          ACT_END: begin
            out_sum          <= end_result;
            data_sum         <= '0;
            pseudo_sum       <= '0;
            held_high_byte   <= '0;
            odd_byte_pending <= 1'b0;
            byte_count       <= '0;
          end
          default: begin
            // unused action code: dropped without effect
          end
        endcase
      end
    end
  end

endmodule
